[rtl/qgi_pkg.sv]
// Shared types, constants and the Hamilton product term table for the gyro integrator.
package qgi_pkg;

  localparam int unsigned QW     = 16;  // quaternion and rate width
  localparam int unsigned TSW    = 16;  // time step width
  localparam int unsigned ACCW   = 34;  // Hamilton product accumulator
  localparam int unsigned TW     = 32;  // rounded sum, 24 fraction bits
  localparam int unsigned AW     = 31;  // magnitude of one rounded sum
  localparam int unsigned SQW    = 64;  // sum of squares / root operand
  localparam int unsigned MW     = 32;  // root
  localparam int unsigned QUOW   = 16;  // quotient bits per output
  localparam int unsigned NUMW   = 46;  // dividend width
  localparam logic [TSW-1:0] TimeStepReset = 16'd655;

  // Controller to datapath commands.
  typedef struct packed {
    logic       load;
    logic       mac;
    logic       scale;
    logic       sq;
    logic       sqrt_step;
    logic       div_init;
    logic       div_step;
    logic       div_wr;
    logic       out_en;
    logic       out_pass;
    logic       out_zero;
    logic [1:0] comp;
    logic [1:0] sub;
    logic [4:0] step;
  } qgi_cmd_t;

  typedef struct packed {
    logic m_zero;
  } qgi_sts_t;

  typedef struct packed {
    logic [1:0] qi;
    logic [1:0] wi;
    logic       neg;
  } qgi_term_t;

  // p = q * (0, w): three signed terms per component
  function automatic qgi_term_t term_sel(input logic [1:0] comp, input logic [1:0] sub);
    qgi_term_t t;
    t = '0;
    unique case ({comp, sub})
      4'b00_00: t = '{qi: 2'd1, wi: 2'd0, neg: 1'b1};
      4'b00_01: t = '{qi: 2'd2, wi: 2'd1, neg: 1'b1};
      4'b00_10: t = '{qi: 2'd3, wi: 2'd2, neg: 1'b1};
      4'b01_00: t = '{qi: 2'd0, wi: 2'd0, neg: 1'b0};
      4'b01_01: t = '{qi: 2'd2, wi: 2'd2, neg: 1'b0};
      4'b01_10: t = '{qi: 2'd3, wi: 2'd1, neg: 1'b1};
      4'b10_00: t = '{qi: 2'd0, wi: 2'd1, neg: 1'b0};
      4'b10_01: t = '{qi: 2'd1, wi: 2'd2, neg: 1'b1};
      4'b10_10: t = '{qi: 2'd3, wi: 2'd0, neg: 1'b0};
      4'b11_00: t = '{qi: 2'd0, wi: 2'd2, neg: 1'b0};
      4'b11_01: t = '{qi: 2'd1, wi: 2'd1, neg: 1'b0};
      4'b11_10: t = '{qi: 2'd2, wi: 2'd0, neg: 1'b1};
      default:  t = '0;
    endcase
    return t;
  endfunction

endpackage

[rtl/qgi_ctrl.sv]
// Sequencer for the gyro integrator: product, root and divide phases.
module qgi_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  logic              compass_present_i,
  input  qgi_pkg::qgi_sts_t sts_i,
  output logic              busy,
  output qgi_pkg::qgi_cmd_t cmd_o
);
  import qgi_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_MAC   = 4'd1;
  localparam logic [3:0] S_SCALE = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_SQRT  = 4'd4;
  localparam logic [3:0] S_DIVI  = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_DIVW  = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;

  logic [3:0] state_q, state_d;
  logic [1:0] comp_q, comp_d;
  logic [1:0] sub_q, sub_d;
  logic [4:0] step_q, step_d;
  logic       started_q, started_d;
  logic       pass_q, pass_d;
  logic       zero_q, zero_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      comp_q    <= '0;
      sub_q     <= '0;
      step_q    <= '0;
      started_q <= 1'b0;
      pass_q    <= 1'b0;
      zero_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      comp_q    <= comp_d;
      sub_q     <= sub_d;
      step_q    <= step_d;
      started_q <= started_d;
      pass_q    <= pass_d;
      zero_q    <= zero_d;
    end
  end

  always_comb begin
    state_d   = state_q;
    comp_d    = comp_q;
    sub_d     = sub_q;
    step_d    = step_q;
    started_d = started_q;
    pass_d    = pass_q;
    zero_d    = zero_q;
    cmd_o      = '0;
    cmd_o.comp = comp_q;
    cmd_o.sub  = sub_q;
    cmd_o.step = step_q;
    unique case (state_q)
      S_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          zero_d     = 1'b0;
          comp_d     = '0;
          sub_d      = '0;
          if (!started_q && !compass_present_i) begin
            pass_d  = 1'b1;
            state_d = S_OUT;
          end else begin
            pass_d    = 1'b0;
            started_d = 1'b1;
            state_d   = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd_o.mac = 1'b1;
        if (sub_q == 2'd2) begin
          sub_d   = '0;
          state_d = S_SCALE;
        end else begin
          sub_d = sub_q + 2'd1;
        end
      end
      S_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = S_SQ;
      end
      S_SQ: begin
        cmd_o.sq = 1'b1;
        comp_d   = comp_q + 2'd1;
        step_d   = '0;
        state_d  = (comp_q == 2'd3) ? S_SQRT : S_MAC;
      end
      S_SQRT: begin
        cmd_o.sqrt_step = 1'b1;
        step_d          = step_q + 5'd1;
        if (step_q == 5'd31) begin
          comp_d  = '0;
          state_d = S_DIVI;
        end
      end
      S_DIVI: begin
        step_d = '0;
        if (sts_i.m_zero) begin
          zero_d  = 1'b1;
          state_d = S_OUT;
        end else begin
          cmd_o.div_init = 1'b1;
          state_d        = S_DIV;
        end
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        step_d         = step_q + 5'd1;
        if (step_q == 5'd15) state_d = S_DIVW;
      end
      S_DIVW: begin
        cmd_o.div_wr = 1'b1;
        comp_d       = comp_q + 2'd1;
        state_d      = (comp_q == 2'd3) ? S_OUT : S_DIVI;
      end
      S_OUT: begin
        cmd_o.out_en   = 1'b1;
        cmd_o.out_pass = pass_q | zero_q;
        cmd_o.out_zero = zero_q;
        state_d        = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  assign busy = (state_q != S_IDLE);

endmodule

[rtl/qgi_datapath.sv]
// Datapath: product accumulator, scaling, sum of squares, bitwise root and divider.
module qgi_datapath (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  qgi_pkg::qgi_cmd_t          cmd_i,
  output qgi_pkg::qgi_sts_t          sts_o,
  input  logic                       time_step_valid_i,
  input  logic [qgi_pkg::TSW-1:0]    time_step_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_w_in_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_x_in_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_y_in_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_z_in_i,
  input  logic signed [qgi_pkg::QW-1:0] rate_x_i,
  input  logic signed [qgi_pkg::QW-1:0] rate_y_i,
  input  logic signed [qgi_pkg::QW-1:0] rate_z_i,
  output logic signed [qgi_pkg::QW-1:0] quat_w_out_o,
  output logic signed [qgi_pkg::QW-1:0] quat_x_out_o,
  output logic signed [qgi_pkg::QW-1:0] quat_y_out_o,
  output logic signed [qgi_pkg::QW-1:0] quat_z_out_o,
  output logic                       integrated_o,
  output logic                       zero_magnitude_o,
  output logic                       result_valid_o
);
  import qgi_pkg::*;

  logic [TSW-1:0]        ts_q;
  logic signed [QW-1:0]  q_q [4];
  logic signed [QW-1:0]  w_q [3];
  logic signed [ACCW-1:0] acc_q;
  logic signed [TW-1:0]  t_q [4];
  logic [SQW-1:0]        n_q, res_q;
  logic [MW:0]           rem_q;
  logic [QUOW-1:0]       nlo_q, quo_q;
  logic signed [QW-1:0]  r_q [4];
  logic signed [QW-1:0]  o_q [4];
  logic                  integ_q, zm_q, valid_q;

  qgi_term_t             term;
  logic signed [2*QW-1:0] prod;
  logic signed [ACCW-1:0] acc_base, acc_d;
  logic signed [ACCW+TSW:0] scaled;
  logic signed [ACCW+TSW+1:0] s_sum;
  logic [TW-1:0]         t_abs;
  logic [AW-1:0]         a_mag;
  logic [2*AW-1:0]       a_sq;
  logic [5:0]            sh;
  logic [SQW-1:0]        bitv, trial;
  logic [MW-1:0]         m;
  logic [NUMW-1:0]       num;
  logic [MW:0]           r2;
  logic                  ge;
  logic [QUOW:0]         neg_r;
  logic signed [QW-1:0]  sat;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ts_q    <= TimeStepReset;
      valid_q <= 1'b0;
    end else begin
      if (time_step_valid_i) ts_q <= time_step_i;
      valid_q <= cmd_i.out_en;
    end
  end

  always_comb begin
    term     = term_sel(cmd_i.comp, cmd_i.sub);
    prod     = q_q[term.qi] * w_q[term.wi];
    acc_base = (cmd_i.sub == 2'd0) ? '0 : acc_q;
    acc_d    = term.neg ? acc_base - ACCW'(prod) : acc_base + ACCW'(prod);
    scaled   = acc_q * $signed({1'b0, ts_q});
    s_sum    = (ACCW+TSW+2)'(scaled)
             + ((ACCW+TSW+2)'(q_q[cmd_i.comp]) <<< 28)
             + (ACCW+TSW+2)'(1 << 17);
    t_abs    = t_q[cmd_i.comp][TW-1] ? (TW)'(-t_q[cmd_i.comp]) : t_q[cmd_i.comp];
    a_mag    = t_abs[AW-1:0];
    a_sq     = a_mag * a_mag;
    sh       = 6'd62 - {cmd_i.step, 1'b0};
    bitv     = SQW'(1) << sh;
    trial    = (res_q >> 1) + bitv;
    m        = res_q[MW-1:0];
    num      = {1'b0, a_mag, 14'd0} + NUMW'(m >> 1);
    r2       = {rem_q[MW-1:0], nlo_q[QUOW-1]};
    ge       = (r2 >= {1'b0, m});
    neg_r    = -{1'b0, quo_q};
    if (t_q[cmd_i.comp][TW-1]) begin
      sat = (quo_q > 16'd32768) ? -16'sd32768 : $signed(neg_r[QW-1:0]);
    end else begin
      sat = quo_q[QUOW-1] ? 16'sd32767 : $signed(quo_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      q_q[0] <= quat_w_in_i;
      q_q[1] <= quat_x_in_i;
      q_q[2] <= quat_y_in_i;
      q_q[3] <= quat_z_in_i;
      w_q[0] <= rate_x_i;
      w_q[1] <= rate_y_i;
      w_q[2] <= rate_z_i;
      n_q    <= '0;
      res_q  <= '0;
    end
    if (cmd_i.mac) acc_q <= acc_d;
    if (cmd_i.scale) t_q[cmd_i.comp] <= TW'(s_sum >>> 18);
    if (cmd_i.sq) n_q <= n_q + SQW'(a_sq);
    // one result bit per cycle; res_q holds res + bit ahead of the shift
    if (cmd_i.sqrt_step) begin
      if (n_q >= res_q + bitv) begin
        n_q   <= n_q - (res_q + bitv);
        res_q <= trial;
      end else begin
        res_q <= res_q >> 1;
      end
    end
    if (cmd_i.div_init) begin
      rem_q <= (MW+1)'(num[NUMW-1:QUOW]);
      nlo_q <= num[QUOW-1:0];
      quo_q <= '0;
    end
    if (cmd_i.div_step) begin
      rem_q <= ge ? r2 - {1'b0, m} : r2;
      nlo_q <= {nlo_q[QUOW-2:0], 1'b0};
      quo_q <= {quo_q[QUOW-2:0], ge};
    end
    if (cmd_i.div_wr) r_q[cmd_i.comp] <= sat;
    if (cmd_i.out_en) begin
      for (int i = 0; i < 4; i++) o_q[i] <= cmd_i.out_pass ? q_q[i] : r_q[i];
      integ_q <= !cmd_i.out_pass;
      zm_q    <= cmd_i.out_zero;
    end
  end

  assign sts_o.m_zero     = (res_q == '0);
  assign quat_w_out_o     = o_q[0];
  assign quat_x_out_o     = o_q[1];
  assign quat_y_out_o     = o_q[2];
  assign quat_z_out_o     = o_q[3];
  assign integrated_o     = integ_q;
  assign zero_magnitude_o = zm_q;
  assign result_valid_o   = valid_q;

endmodule

[rtl/quaternion_gyro_integrator.sv]
// Top level of the first-order quaternion gyro integrator.
// One integrating transaction runs load, the Hamilton product and sum of squares,
// the bit-pair square root, the radix-2 divider for each component and output;
// pass-through goes from load straight to output, and zero magnitude leaves out
// the divider. busy is high from the accepting edge until the
// result cycle; the result appears on the output ports for one cycle with result_valid_o,
// while busy is already low, and the receiver cannot stall it. The time step write
// channel is always ready and must only be used while busy is low.
module quaternion_gyro_integrator (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          time_step_valid_i,
  output logic                          time_step_ready_o,
  input  logic [qgi_pkg::TSW-1:0]       time_step_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_w_in_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_x_in_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_y_in_i,
  input  logic signed [qgi_pkg::QW-1:0] quat_z_in_i,
  input  logic signed [qgi_pkg::QW-1:0] rate_x_i,
  input  logic signed [qgi_pkg::QW-1:0] rate_y_i,
  input  logic signed [qgi_pkg::QW-1:0] rate_z_i,
  input  logic                          compass_present_i,
  output logic                          result_valid_o,
  output logic signed [qgi_pkg::QW-1:0] quat_w_out_o,
  output logic signed [qgi_pkg::QW-1:0] quat_x_out_o,
  output logic signed [qgi_pkg::QW-1:0] quat_y_out_o,
  output logic signed [qgi_pkg::QW-1:0] quat_z_out_o,
  output logic                          integrated_o,
  output logic                          zero_magnitude_o
);
  import qgi_pkg::*;

  qgi_cmd_t cmd;
  qgi_sts_t sts;

  assign time_step_ready_o = 1'b1;

  qgi_ctrl u_ctrl (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .compass_present_i (compass_present_i),
    .sts_i             (sts),
    .busy              (busy),
    .cmd_o             (cmd)
  );

  qgi_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .time_step_valid_i (time_step_valid_i),
    .time_step_i       (time_step_i),
    .quat_w_in_i       (quat_w_in_i),
    .quat_x_in_i       (quat_x_in_i),
    .quat_y_in_i       (quat_y_in_i),
    .quat_z_in_i       (quat_z_in_i),
    .rate_x_i          (rate_x_i),
    .rate_y_i          (rate_y_i),
    .rate_z_i          (rate_z_i),
    .quat_w_out_o      (quat_w_out_o),
    .quat_x_out_o      (quat_x_out_o),
    .quat_y_out_o      (quat_y_out_o),
    .quat_z_out_o      (quat_z_out_o),
    .integrated_o      (integrated_o),
    .zero_magnitude_o  (zero_magnitude_o),
    .result_valid_o    (result_valid_o)
  );

endmodule
